@@ hdl/psq_pkg.sv @@
package psq_pkg;

  localparam int unsigned PSQ_DEPTH   = 128;
  localparam int unsigned PSQ_VALUE_W = 32;
  localparam int unsigned PSQ_PRI_W   = 3;
  localparam int unsigned PSQ_COUNT_W = 8;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } psq_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } psq_status_e;

  typedef struct packed {
    logic signed [PSQ_VALUE_W-1:0] value;
    logic        [PSQ_PRI_W-1:0]   pri;
  } psq_entry_t;

  // Operation broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic       enq;
    logic       deq;
    psq_entry_t entry;
  } psq_op_t;

endpackage

@@ hdl/psq_cell.sv @@
module psq_cell
  import psq_pkg::*;
(
  input  logic       clk_i,
  input  psq_op_t    op_i,
  input  logic       occ_i,
  input  psq_entry_t left_i,
  input  logic       left_gt_i,
  input  psq_entry_t right_i,
  output psq_entry_t entry_o,
  output logic       gt_o
);

  psq_entry_t entry_q, entry_d;

  // An empty slot or a held entry of larger priority number yields to the new word.
  assign gt_o    = !occ_i || (entry_q.pri > op_i.entry.pri);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.enq) begin
      if (gt_o) begin
        entry_d = left_gt_i ? left_i : op_i.entry;
      end
    end else if (op_i.deq) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hdl/priority_sorted_queue.sv @@
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o  command_i, value_i, priority_req_i
// output   out        out_valid_o / out_stall_i status_o, out_value_o, out_priority_o, count_o
//
// Each word is accepted, applied to the cell chain and its result registered
// at the same clock edge, so one word per cycle is sustained while the output is not stalled.
// The insert position is found by the broadcast compare in every cell of the chain.
// Reset clears the entry count and the output valid; cell contents need no reset.
// The input stalls only while a finished result waits and the output is stalled.
module priority_sorted_queue
  import psq_pkg::*;
#(
  parameter int unsigned DEPTH = PSQ_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic signed [PSQ_VALUE_W-1:0] value_i,
  input  logic        [PSQ_PRI_W-1:0]   priority_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic        [1:0]             status_o,
  output logic signed [PSQ_VALUE_W-1:0] out_value_o,
  output logic        [PSQ_PRI_W-1:0]   out_priority_o,
  output logic        [PSQ_COUNT_W-1:0] count_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Occupancy is kept as a count; cell i holds an entry when i is below it.
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  psq_status_e      status_q, status_d;
  psq_entry_t       out_entry_q, out_entry_d;
  logic [PSQ_COUNT_W-1:0] out_count_q;
  logic [CNT_W+PSQ_COUNT_W-1:0] count_ext;

  logic    accept;
  logic    full, empty;
  psq_op_t op;

  psq_entry_t cell_entry [DEPTH];
  logic       cell_gt    [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);

  // Refused operations leave the chain untouched.
  assign op.enq         = accept && (command_i == CMD_ENQ) && !full;
  assign op.deq         = accept && (command_i == CMD_DEQ) && !empty;
  assign op.entry.value = value_i;
  assign op.entry.pri   = priority_req_i;

  // The chain: each cell takes the new word, its left neighbor's entry on an
  // insert ahead of it, or its right neighbor's entry on a removal at the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occ;
    psq_entry_t left;
    logic       left_gt;
    psq_entry_t right;

    assign occ = (count_q > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left    = op.entry;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = cell_entry[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    psq_cell u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .occ_i     (occ),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .entry_o   (cell_entry[i]),
      .gt_o      (cell_gt[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    status_d    = ST_DONE;
    out_entry_d = '0;
    if (command_i == CMD_ENQ) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        count_d     = count_q - CNT_W'(1);
        out_entry_d = cell_entry[0];
      end
    end
  end

  // The reported count carries the low bits of the true count.
  assign count_ext = {{PSQ_COUNT_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      out_entry_q <= out_entry_d;
      out_count_q <= count_ext[PSQ_COUNT_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_value_o    = out_entry_q.value;
  assign out_priority_o = out_entry_q.pri;
  assign count_o        = out_count_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the sorted priority queue. A shadow copy of the
// queue predicts every result, and each result word that leaves the block is
// compared field by field against the oldest prediction still waiting.
module testbench;
  import psq_pkg::*;

  // The watchdog gives up after this many cycles in which neither channel
  // moves a word. Stalls and gaps are short random runs, so a healthy block
  // never comes close.
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned IDLE_PCT    = 15;
  localparam int unsigned DRAIN_WAIT  = 10;

  // One predicted result word of the block.
  typedef struct {
    psq_status_e                   status;
    logic signed [PSQ_VALUE_W-1:0] value;
    logic        [PSQ_PRI_W-1:0]   pri;
    logic        [PSQ_COUNT_W-1:0] count;
  } queue_result_t;

  // Shadow queue: it holds the entries in the order that the block should
  // hold them, and the results that the block still owes.
  class sorted_queue_tracker;
    psq_entry_t    shadow_entries[$];
    queue_result_t owed_results[$];
    int unsigned   errors;

    function new();
      errors = 0;
    endfunction

    // Applies one accepted command word to the shadow queue and records the
    // result that the block has to return for it.
    function void note_accepted(psq_cmd_e cmd, logic signed [PSQ_VALUE_W-1:0] val,
                                logic [PSQ_PRI_W-1:0] pri);
      queue_result_t res;
      psq_entry_t    ent;
      int            pos;
      res.status = ST_DONE;
      res.value  = '0;
      res.pri    = '0;
      if (cmd == CMD_ENQ) begin
        if (shadow_entries.size() >= PSQ_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // The new entry goes behind every entry of equal or smaller number,
          // which keeps equal priorities in arrival order.
          pos = 0;
          while (pos < shadow_entries.size() && shadow_entries[pos].pri <= pri) begin
            pos++;
          end
          ent.value = val;
          ent.pri   = pri;
          shadow_entries.insert(pos, ent);
        end
      end else begin
        if (shadow_entries.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ent = shadow_entries.pop_front();
          res.value = ent.value;
          res.pri   = ent.pri;
        end
      end
      res.count = PSQ_COUNT_W'(shadow_entries.size());
      owed_results.push_back(res);
    endfunction

    // Compares one accepted result word with the oldest owed result.
    function void check_result(logic [1:0] status, logic signed [PSQ_VALUE_W-1:0] val,
                               logic [PSQ_PRI_W-1:0] pri, logic [PSQ_COUNT_W-1:0] count);
      queue_result_t exp_res;
      if (owed_results.size() == 0) begin
        $display("%0t: result word with nothing owed: status %0d value %0d pri %0d count %0d",
                 $time, status, val, pri, count);
        errors++;
      end else begin
        exp_res = owed_results.pop_front();
        if (status !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
          errors++;
        end
        if (val !== exp_res.value) begin
          $display("%0t: out_value expected %0d actual %0d", $time, exp_res.value, val);
          errors++;
        end
        if (pri !== exp_res.pri) begin
          $display("%0t: out_priority expected %0d actual %0d", $time, exp_res.pri, pri);
          errors++;
        end
        if (count !== exp_res.count) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_res.count, count);
          errors++;
        end
      end
    endfunction

    function int owed();
      return owed_results.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_stall_o;
  logic                          command_i      = 1'b0;
  logic signed [PSQ_VALUE_W-1:0] value_i        = '0;
  logic        [PSQ_PRI_W-1:0]   priority_req_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i    = 1'b0;
  logic        [1:0]             status_o;
  logic signed [PSQ_VALUE_W-1:0] out_value_o;
  logic        [PSQ_PRI_W-1:0]   out_priority_o;
  logic        [PSQ_COUNT_W-1:0] count_o;

  // While calm is set neither side inserts gaps or stalls, so the block
  // also sees long runs of back-to-back words.
  bit calm = 1'b0;

  sorted_queue_tracker tracker = new();

  priority_sorted_queue u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .count_o        (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Presents one command word and returns at the edge where it is taken.
  // Any gap comes first, so valid is written once per edge: it only drops
  // when a gap is chosen and otherwise stays high into the next word.
  task automatic send_word(psq_cmd_e cmd, logic signed [PSQ_VALUE_W-1:0] val,
                           logic [PSQ_PRI_W-1:0] pri);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    value_i        <= val;
    priority_req_i <= pri;
    // Signals read right after the edge still hold their pre-edge values,
    // which are the ones the block saw when deciding to take the word.
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    tracker.note_accepted(cmd, val, pri);
  endtask

  // Sends a run of random words. enq_pct sets how many are enqueues, which
  // steers the queue toward full or toward empty. Value and priority are
  // random on dequeues too, since the block has to ignore them there.
  task automatic run_random(int unsigned n, int unsigned enq_pct);
    psq_cmd_e                      cmd;
    logic signed [PSQ_VALUE_W-1:0] val;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < enq_pct) begin
        cmd = CMD_ENQ;
      end else begin
        cmd = CMD_DEQ;
      end
      case ($urandom_range(0, 9))
        0:       val = 32'sh8000_0000;
        1:       val = 32'sh7fff_ffff;
        2:       val = '0;
        3:       val = -32'sd1;
        default: val = $urandom;
      endcase
      send_word(cmd, val, PSQ_PRI_W'($urandom_range(0, 7)));
    end
  endtask

  // Result side: take a word whenever valid is up and stall is low at the
  // edge, then choose the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_result(status_o, out_value_o, out_priority_o, count_o);
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: any cycle with a word moving on either channel resets it.
  initial begin : watchdog
    int unsigned quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening. A dequeue on the empty queue must be refused, with
    // nonzero ignored fields to show they do not leak into the result.
    send_word(CMD_DEQ, -32'sd1, 3'd7);
    // Extreme data words across the priority range, including the two
    // numbers above five, which simply sort behind everything else.
    send_word(CMD_ENQ, 32'sh7fff_ffff, 3'd5);
    send_word(CMD_ENQ, 32'sh8000_0000, 3'd0);
    send_word(CMD_ENQ, 32'sd0, 3'd3);
    send_word(CMD_ENQ, -32'sd1, 3'd3);
    send_word(CMD_ENQ, 32'sd6, 3'd7);
    send_word(CMD_ENQ, 32'sd5, 3'd6);
    // A second priority zero must come out behind the first one.
    send_word(CMD_ENQ, 32'sh1234_5678, 3'd0);
    send_word(CMD_ENQ, 32'sd1, 3'd1);
    send_word(CMD_ENQ, 32'sd2, 3'd2);
    send_word(CMD_ENQ, 32'sd4, 3'd4);
    send_word(CMD_ENQ, 32'sh5555_aaaa, 3'd3);
    // Drain everything and refuse once more on the empty queue.
    repeat (12) send_word(CMD_DEQ, 32'shdead_beef, 3'd5);

    // Mostly enqueues: the queue fills and enqueues get refused as full.
    run_random(200, 90);
    // Mostly dequeues: it drains and dequeues get refused as empty.
    run_random(200, 12);
    // Back-to-back traffic with no gaps or stalls on either side.
    calm = 1'b1;
    run_random(150, 55);
    calm = 1'b0;
    // Mixed traffic hovering around the middle of the queue.
    run_random(100, 60);
    run_random(100, 45);

    in_valid_i <= 1'b0;
    while (tracker.owed() != 0) begin
      @(posedge clk_i);
    end
    // Give a stray extra result word time to show up.
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
